// File: sv/assert_macros.svh
// Assertion helpers included by bitcrusher_fold_quantize.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define BFQ_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside reset.
`define BFQ_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    `BFQ_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: sv/bfq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfq_pkg
// Shared constants and types of the fold/quantize bit crusher.
// ----------------------------------------------------------------------------
package bfq_pkg;

    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF   = 32;
    localparam int RAMP_BITS       = 32;
    localparam int RAMP_FRAC       = 30;
    localparam int CFG_IDX_BITS    = 3;
    localparam int SCALE_RESET     = 65536;
    localparam int FOLD_RESET      = 1467700000;

    localparam logic [RAMP_BITS-1:0] RAMP_ONE = 32'h4000_0000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_STEP_START  = 3'd0,
        CFG_STEP_RAMP   = 3'd1,
        CFG_SCALE_START = 3'd2,
        CFG_SCALE_RAMP  = 3'd3,
        CFG_FOLD_START  = 3'd4,
        CFG_FOLD_RAMP   = 3'd5
    } cfg_idx_t;

    typedef enum logic [0:0] {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

endpackage

// File: sv/bfq_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfq_alu
// Serial shift-add multiplier / restoring divider, one bit per cycle,
// built around a single shared adder.
// ----------------------------------------------------------------------------
module bfq_alu #(
    parameter int PW = 66,
    parameter int MB = 32,
    parameter int DW = 35,
    parameter int CW = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bfq_pkg::alu_cmd_t  cmd,
    input  logic [CW-1:0]      count,
    input  logic [PW-1:0]      mcand,
    input  logic [MB-1:0]      mplier,
    input  logic [DW-1:0]      divisor,
    input  logic [DW-1:0]      dividend,
    input  logic [DW-1:0]      rem_init,
    output bfq_pkg::alu_stat_t stat,
    output logic [PW-1:0]      prod,
    output logic [DW-1:0]      quo,
    output logic [DW-1:0]      rem
);
    import bfq_pkg::*;

    alu_op_t       op_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] mcand_reg;
    logic [MB-1:0] mplier_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] num_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW-1:0] quo_reg;

    logic [DW-1:0] shifted;
    logic [PW-1:0] opa;
    logic [PW-1:0] opb;
    logic          cin;
    logic [PW:0]   sum;
    logic          carry;

    // shared adder: accumulate for multiply, trial subtract for divide
    always_comb
    begin
        shifted = {rem_reg[DW-2:0], num_reg[DW-1]};
        if (op_reg == OP_MUL)
        begin
            opa = acc_reg;
            opb = mplier_reg[0] ? mcand_reg : '0;
            cin = 1'b0;
        end
        else
        begin
            opa = {{(PW-DW){1'b0}}, shifted};
            opb = ~{{(PW-DW){1'b0}}, dvs_reg};
            cin = 1'b1;
        end
        sum   = {1'b0, opa} + {1'b0, opb} + {{PW{1'b0}}, cin};
        carry = sum[PW];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= OP_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                op_reg   <= cmd.op;
                busy_reg <= 1'b1;
                cnt_reg  <= count;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= mcand;
            mplier_reg <= mplier;
            rem_reg    <= rem_init;
            num_reg    <= dividend;
            dvs_reg    <= divisor;
            quo_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                acc_reg    <= sum[PW-1:0];
                mcand_reg  <= {mcand_reg[PW-2:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[MB-1:1]};
            end
            else
            begin
                rem_reg <= carry ? sum[DW-1:0] : shifted;
                quo_reg <= {quo_reg[DW-2:0], carry};
                num_reg <= {num_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign prod      = acc_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;

endmodule

// File: sv/bitcrusher_fold_quantize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcrusher_fold_quantize
// Sample-and-hold bit crusher with wave folding and level quantization.
// ----------------------------------------------------------------------------
// One transfer on the input channel gives exactly one transfer on the output
// channel. A zero sample comes back as zero and leaves the state alone (a
// start_tick reload still happens). Any other sample advances the phase and,
// on a phase wrap, also runs the ratio divide, lerp multiply, fold modulo,
// quantizer divide and multiply and output blend multiply. Every multiply,
// divide and modulo goes through the single serial shift-add/subtract unit,
// which handles one bit per cycle, and three ramp multiplies are done after
// every non-zero sample. in_ready is low while a sample is being worked on; a
// finished result waits in the output register, so the next sample can be
// taken before it is drained. Configuration writes are always taken (cfg_ready
// is high) and must only be issued while the block is idle; indexes 6 and 7
// are ignored.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitcrusher_fold_quantize #(
    parameter int SAMPLE_BITS = bfq_pkg::SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = bfq_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input samples
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [SAMPLE_BITS-1:0]    sample_in,
    input  logic                             start_tick,
    // output samples
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [SAMPLE_BITS-1:0]    sample_out,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bfq_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [((FRAC_BITS+1 > bfq_pkg::RAMP_BITS) ?
                   FRAC_BITS+1 : bfq_pkg::RAMP_BITS)-1:0] cfg_data
);
    import bfq_pkg::*;

    localparam int F    = FRAC_BITS;
    localparam int S    = SAMPLE_BITS;
    localparam int LW   = F + 4;                 // wide signed working format
    localparam int MB   = (F > RAMP_BITS) ? F : RAMP_BITS;
    localparam int PW   = F + 2 + MB;            // product width
    localparam int DW   = F + 3;                 // divider width
    localparam int CW   = $clog2(PW + 1);
    localparam int D    = F - S + 1;             // sample to wide shift
    localparam int DPOS = (D > 0) ? D : 0;
    localparam int DNEG = (D < 0) ? -D : 0;
    localparam int TW   = LW + DNEG;

    localparam logic [F:0]   ONE_LEVEL = {1'b1, {F{1'b0}}};
    localparam logic [F-1:0] LEVEL_MAX = '1;
    localparam logic [F-1:0] LEVEL_MIN = F'(1);
    localparam logic [S-1:0] SMAX      = {1'b0, {(S-1){1'b1}}};
    localparam logic [S-1:0] SMIN      = {1'b1, {(S-1){1'b0}}};

    // one-hot sequencer
    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_ADV    = 12'b0000_0000_0010,
        S_RATIO  = 12'b0000_0000_0100,
        S_LERP   = 12'b0000_0000_1000,
        S_MOD    = 12'b0000_0001_0000,
        S_QDIV   = 12'b0000_0010_0000,
        S_QMUL   = 12'b0000_0100_0000,
        S_OUTMUL = 12'b0000_1000_0000,
        S_RSTEP  = 12'b0001_0000_0000,
        S_RSCALE = 12'b0010_0000_0000,
        S_RFOLD  = 12'b0100_0000_0000,
        S_FINISH = 12'b1000_0000_0000
    } state_t;

    // configuration registers
    logic [F:0]           step_start_reg;
    logic [RAMP_BITS-1:0] step_ramp_reg;
    logic [F-1:0]         scale_start_reg;
    logic [RAMP_BITS-1:0] scale_ramp_reg;
    logic [F-1:0]         fold_start_reg;
    logic [RAMP_BITS-1:0] fold_ramp_reg;

    // block state
    state_t       state_reg, state_next;
    logic         go_reg, go_next;
    logic [S-1:0] last_reg, last_next;
    logic [S-1:0] held_reg, held_next;
    logic [F-1:0] phase_reg, phase_next;
    logic [F:0]   step_run_reg, step_run_next;
    logic [F-1:0] scale_run_reg, scale_run_next;
    logic [F-1:0] fold_run_reg, fold_run_next;
    logic         out_valid_reg, out_valid_next;
    logic [S-1:0] out_data_reg, out_data_next;

    // per-sample working registers
    logic [S-1:0]  x_reg, x_next;
    logic [F-1:0]  ratio_reg, ratio_next;
    logic [LW-1:0] lerp_reg, lerp_next;
    logic [LW-1:0] folded_reg, folded_next;
    logic [LW-1:0] m_reg, m_next;
    logic [S-1:0]  new_reg, new_next;
    logic [S-1:0]  res_reg, res_next;

    // shared unit
    alu_cmd_t      alu_cmd;
    alu_stat_t     alu_stat;
    logic [CW-1:0] alu_count;
    logic [PW-1:0] alu_mcand;
    logic [MB-1:0] alu_mplier;
    logic [DW-1:0] alu_divisor;
    logic [DW-1:0] alu_dividend;
    logic [DW-1:0] alu_rem_init;
    logic [PW-1:0] alu_prod;
    logic [DW-1:0] alu_quo;
    logic [DW-1:0] alu_rem;

    // datapath helpers
    logic [F+1:0]         phase_sum;
    logic                 wraps;
    logic signed [LW-1:0] x_ext, p_ext, xw, pw;
    logic [LW-1:0]        diff, diff_mag, lmag;
    logic                 diff_neg;
    logic [LW-1:0]        fold_w, v, v_mag;
    logic                 v_neg;
    logic [DW-1:0]        wrap4, tmod;
    logic [LW-1:0]        t2, t2_abs, folded_mag;
    logic                 folded_neg, folded_pos;
    logic [LW-1:0]        q_w, n_w, m_mag;
    logic [LW-1:0]        pval;
    logic signed [LW-1:0] half;
    logic signed [TW-1:0] te, ts;
    logic [S-1:0]         new_s;
    logic [S:0]           d2, d2_mag;
    logic [S+1:0]         r_sum;
    logic [S-1:0]         r_sat;
    logic [F+3:0]         ramped;
    logic [F:0]           step_ramped, step_reload;
    logic [F-1:0]         level_ramped, scale_reload, fold_reload;

    bfq_alu #(
        .PW (PW),
        .MB (MB),
        .DW (DW),
        .CW (CW)
    ) u_alu (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (alu_cmd),
        .count    (alu_count),
        .mcand    (alu_mcand),
        .mplier   (alu_mplier),
        .divisor  (alu_divisor),
        .dividend (alu_dividend),
        .rem_init (alu_rem_init),
        .stat     (alu_stat),
        .prod     (alu_prod),
        .quo      (alu_quo),
        .rem      (alu_rem)
    );

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        // phase advance
        phase_sum = {2'b00, phase_reg} + {1'b0, step_run_reg};
        wraps     = (phase_sum >= {1'b0, ONE_LEVEL}) && (step_run_reg != '0);

        // samples into the wide format
        x_ext = {{(LW-S){x_reg[S-1]}}, x_reg};
        p_ext = {{(LW-S){last_reg[S-1]}}, last_reg};
        xw    = (x_ext <<< DPOS) >>> DNEG;
        pw    = (p_ext <<< DPOS) >>> DNEG;

        // input interpolation: xw + (pw - xw) * ratio, toward zero
        diff     = pw - xw;
        diff_neg = diff[LW-1];
        diff_mag = diff_neg ? -diff : diff;
        lmag     = LW'(alu_prod[PW-1:F]);
        lerp_next = xw + (diff_neg ? -lmag : lmag);

        // wave fold: floor mod of (lerp + fold) over 4*fold
        fold_w = {{(LW-F){1'b0}}, fold_run_reg};
        v      = lerp_reg + fold_w;
        v_neg  = v[LW-1];
        v_mag  = v_neg ? -v : v;
        wrap4  = {{(DW-F-2){1'b0}}, fold_run_reg, 2'b00};
        tmod   = (v_neg && (alu_rem != '0)) ? (wrap4 - alu_rem) : alu_rem;
        t2     = {fold_w[LW-2:0], 1'b0} - {{(LW-DW){1'b0}}, tmod};
        t2_abs = t2[LW-1] ? -t2 : t2;
        folded_next = fold_w - t2_abs;
        folded_neg  = folded_reg[LW-1];
        folded_pos  = !folded_neg && (folded_reg != '0);
        folded_mag  = folded_neg ? -folded_reg : folded_reg;

        // quantizer: n = folded / scale (toward zero) + (folded > 0)
        q_w    = {{(LW-DW){1'b0}}, alu_quo};
        n_w    = folded_neg ? -q_w : (q_w + {{(LW-1){1'b0}}, folded_pos});
        m_next = {n_w[LW-2:0], 1'b0} - LW'(1);
        m_mag  = m_reg[LW-1] ? -m_reg : m_reg;

        // midpoint (2n-1)*scale/2, floored, to a saturated sample
        pval = m_reg[LW-1] ? -alu_prod[LW-1:0] : alu_prod[LW-1:0];
        half = $signed(pval) >>> 1;
        te   = {{(TW-LW){half[LW-1]}}, half};
        ts   = (te <<< DNEG) >>> DPOS;
        if ((&ts[TW-1:S-1]) || !(|ts[TW-1:S-1]))
            new_s = ts[S-1:0];
        else
            new_s = ts[TW-1] ? SMIN : SMAX;

        // output blend of held and new values
        d2     = {new_reg[S-1], new_reg} - {held_reg[S-1], held_reg};
        d2_mag = d2[S] ? -d2 : d2;
        r_sum  = {{2{held_reg[S-1]}}, held_reg}
               + (d2[S] ? -{1'b0, alu_prod[F +: S+1]} : {1'b0, alu_prod[F +: S+1]});
        if ((&r_sum[S+1:S-1]) || !(|r_sum[S+1:S-1]))
            r_sat = r_sum[S-1:0];
        else
            r_sat = r_sum[S+1] ? SMIN : SMAX;

        // ramp products in Q2.30, then limited
        ramped = alu_prod[RAMP_FRAC +: F+4];
        step_ramped  = (ramped > {3'b000, ONE_LEVEL}) ? ONE_LEVEL : ramped[F:0];
        if (ramped > {4'b0000, LEVEL_MAX})
            level_ramped = LEVEL_MAX;
        else if (ramped == '0)
            level_ramped = LEVEL_MIN;
        else
            level_ramped = ramped[F-1:0];

        // tick reload values
        step_reload  = (step_start_reg > ONE_LEVEL) ? ONE_LEVEL : step_start_reg;
        scale_reload = (scale_start_reg == '0) ? LEVEL_MIN : scale_start_reg;
        fold_reload  = (fold_start_reg == '0) ? LEVEL_MIN : fold_start_reg;
    end

    // ------------------------------------------------------- shared unit operands
    always_comb
    begin
        alu_cmd.start = go_reg;
        alu_cmd.op    = OP_MUL;
        alu_count     = CW'(MB);
        alu_mcand     = '0;
        alu_mplier    = '0;
        alu_divisor   = '0;
        alu_dividend  = '0;
        alu_rem_init  = '0;
        case (state_reg)
            S_RATIO:
            begin
                // ratio = phase * 2^F / step
                alu_cmd.op   = OP_DIV;
                alu_count    = CW'(F);
                alu_divisor  = {{(DW-F-1){1'b0}}, step_run_reg};
                alu_rem_init = {{(DW-F){1'b0}}, phase_reg};
            end
            S_LERP:
            begin
                alu_mcand  = {{(PW-LW){1'b0}}, diff_mag};
                alu_mplier = {{(MB-F){1'b0}}, ratio_reg};
            end
            S_MOD:
            begin
                alu_cmd.op   = OP_DIV;
                alu_count    = CW'(F + 1);
                alu_divisor  = wrap4;
                alu_dividend = {v_mag[DW-3:0], 2'b00};
            end
            S_QDIV:
            begin
                alu_cmd.op   = OP_DIV;
                alu_count    = CW'(F);
                alu_divisor  = {{(DW-F){1'b0}}, scale_run_reg};
                alu_dividend = {folded_mag[DW-4:0], 3'b000};
            end
            S_QMUL:
            begin
                alu_mcand  = {{(PW-LW){1'b0}}, m_mag};
                alu_mplier = {{(MB-F){1'b0}}, scale_run_reg};
            end
            S_OUTMUL:
            begin
                alu_mcand  = {{(PW-S-1){1'b0}}, d2_mag};
                alu_mplier = {{(MB-F){1'b0}}, ratio_reg};
            end
            S_RSTEP:
            begin
                alu_mcand  = {{(PW-F-1){1'b0}}, step_run_reg};
                alu_mplier = {{(MB-RAMP_BITS){1'b0}}, step_ramp_reg};
            end
            S_RSCALE:
            begin
                alu_mcand  = {{(PW-F){1'b0}}, scale_run_reg};
                alu_mplier = {{(MB-RAMP_BITS){1'b0}}, scale_ramp_reg};
            end
            S_RFOLD:
            begin
                alu_mcand  = {{(PW-F){1'b0}}, fold_run_reg};
                alu_mplier = {{(MB-RAMP_BITS){1'b0}}, fold_ramp_reg};
            end
            default:
            begin
            end
        endcase
    end

    // --------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        last_next      = last_reg;
        held_next      = held_reg;
        phase_next     = phase_reg;
        step_run_next  = step_run_reg;
        scale_run_next = scale_run_reg;
        fold_run_next  = fold_run_reg;
        x_next         = x_reg;
        ratio_next     = ratio_reg;
        new_next       = new_reg;
        res_next       = res_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = sample_in;
                    if (start_tick)
                    begin
                        step_run_next  = step_reload;
                        scale_run_next = scale_reload;
                        fold_run_next  = fold_reload;
                    end
                    if (sample_in == '0)
                    begin
                        // zero passes straight through; only a start_tick reload touches state
                        res_next   = '0;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ADV;
                    end
                end
            end
            S_ADV:
            begin
                go_next = 1'b1;
                if (wraps)
                begin
                    phase_next = phase_sum[F-1:0];
                    state_next = S_RATIO;
                end
                else
                begin
                    phase_next = phase_sum[F-1:0];
                    last_next  = x_reg;
                    res_next   = held_reg;
                    state_next = S_RSTEP;
                end
            end
            S_RATIO:
            begin
                if (alu_stat.done)
                begin
                    ratio_next = alu_quo[F-1:0];
                    go_next    = 1'b1;
                    state_next = S_LERP;
                end
            end
            S_LERP:
            begin
                if (alu_stat.done)
                begin
                    last_next  = x_reg;
                    go_next    = 1'b1;
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (alu_stat.done)
                begin
                    go_next    = 1'b1;
                    state_next = S_QDIV;
                end
            end
            S_QDIV:
            begin
                if (alu_stat.done)
                begin
                    go_next    = 1'b1;
                    state_next = S_QMUL;
                end
            end
            S_QMUL:
            begin
                if (alu_stat.done)
                begin
                    new_next   = new_s;
                    go_next    = 1'b1;
                    state_next = S_OUTMUL;
                end
            end
            S_OUTMUL:
            begin
                if (alu_stat.done)
                begin
                    res_next   = r_sat;
                    held_next  = new_reg;
                    go_next    = 1'b1;
                    state_next = S_RSTEP;
                end
            end
            S_RSTEP:
            begin
                if (alu_stat.done)
                begin
                    step_run_next = step_ramped;
                    go_next       = 1'b1;
                    state_next    = S_RSCALE;
                end
            end
            S_RSCALE:
            begin
                if (alu_stat.done)
                begin
                    scale_run_next = level_ramped;
                    go_next        = 1'b1;
                    state_next     = S_RFOLD;
                end
            end
            S_RFOLD:
            begin
                if (alu_stat.done)
                begin
                    fold_run_next = level_ramped;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                // output register free or draining this cycle
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            go_reg          <= 1'b0;
            out_valid_reg   <= 1'b0;
            last_reg        <= '0;
            held_reg        <= '0;
            phase_reg       <= '0;
            step_run_reg    <= ONE_LEVEL;
            scale_run_reg   <= F'(SCALE_RESET);
            fold_run_reg    <= F'(FOLD_RESET);
            step_start_reg  <= ONE_LEVEL;
            step_ramp_reg   <= RAMP_ONE;
            scale_start_reg <= F'(SCALE_RESET);
            scale_ramp_reg  <= RAMP_ONE;
            fold_start_reg  <= F'(FOLD_RESET);
            fold_ramp_reg   <= RAMP_ONE;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            held_reg      <= held_next;
            phase_reg     <= phase_next;
            step_run_reg  <= step_run_next;
            scale_run_reg <= scale_run_next;
            fold_run_reg  <= fold_run_next;
            if (cfg_valid)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_STEP_START:  step_start_reg  <= cfg_data[F:0];
                    CFG_STEP_RAMP:   step_ramp_reg   <= cfg_data[RAMP_BITS-1:0];
                    CFG_SCALE_START: scale_start_reg <= cfg_data[F-1:0];
                    CFG_SCALE_RAMP:  scale_ramp_reg  <= cfg_data[RAMP_BITS-1:0];
                    CFG_FOLD_START:  fold_start_reg  <= cfg_data[F-1:0];
                    CFG_FOLD_RAMP:   fold_ramp_reg   <= cfg_data[RAMP_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        ratio_reg    <= ratio_next;
        new_reg      <= new_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
        if (state_reg == S_LERP && alu_stat.done)
            lerp_reg <= lerp_next;
        if (state_reg == S_MOD && alu_stat.done)
            folded_reg <= folded_next;
        if (state_reg == S_QDIV && alu_stat.done)
            m_reg <= m_next;
    end

    // --------------------------------------------------------------- assertions
    `BFQ_ASSERT(a_step_le_one, clk, rst_n, step_run_reg <= ONE_LEVEL, "step above one")
    `BFQ_ASSERT_NEVER(a_level_zero, clk, rst_n,
        (scale_run_reg == '0) || (fold_run_reg == '0), "zero scale or fold level")
    `BFQ_ASSERT(a_busy_after_xfer, clk, rst_n,
        (in_valid && in_ready) |=> !in_ready, "input taken twice in a row")
    `BFQ_ASSERT_NEVER(a_go_while_busy, clk, rst_n,
        go_reg && alu_stat.busy, "shared unit restarted while busy")

endmodule

// File: sim/bitcrusher_fold_quantize_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitcrusher_fold_quantize_test
// Self-checking bench for the fold/quantize bit crusher.
// ----------------------------------------------------------------------------
// A local bit-exact crusher model predicts every output sample when its input
// transfer is accepted. The output monitor checks transfers in order against
// the predicted samples. Stimulus runs in phases with different register
// settings and different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module bitcrusher_fold_quantize_test;
    import bfq_pkg::*;

    localparam int SB       = 24;
    localparam int FB       = 32;
    localparam int WD_LIMIT = 20000;
    localparam longint SMAX = (64'sd1 <<< (SB - 1)) - 1;
    localparam longint SMIN = -SMAX - 1;
    localparam bit [63:0] ONE_LVL = 64'd1 << FB;

    typedef struct {
        logic signed [SB-1:0] smp;
        logic                 tick;
    } sample_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [SB-1:0] sample_in = '0;
    logic start_tick = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [SB-1:0] sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [32:0] cfg_data = '0;

    bitcrusher_fold_quantize dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .sample_in(sample_in), .start_tick(start_tick),
        .out_valid(out_valid), .out_ready(out_ready), .sample_out(sample_out),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // pending input samples and predicted crushed samples
    sample_item_t pending_q[$];
    logic signed [SB-1:0] crushed_q[$];
    int sent_cnt = 0;
    int taken_cnt = 0;
    int mismatch_cnt = 0;
    int stuck_cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // model copy of registers and state
    bit [63:0] r_step_start, r_step_ramp, r_scale_start, r_scale_ramp;
    bit [63:0] r_fold_start, r_fold_ramp;
    longint last_in, held_out;
    bit [63:0] phase, cur_step, cur_scale, cur_fold;

    function automatic bit [63:0] ramp_mul(bit [63:0] a, bit [63:0] b, int sh);
        bit [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> sh;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    // signed times unsigned fraction, truncated toward zero
    function automatic longint frac_mul(longint a, bit [63:0] b);
        bit [63:0] mag;
        bit [63:0] r;
        mag = (a < 0) ? -a : a;
        r = ramp_mul(mag, b, FB);
        if (r > 64'h7FFF_FFFF_FFFF_FFFF) r = 64'h7FFF_FFFF_FFFF_FFFF;
        return (a < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic bit [63:0] level_clamp(bit [63:0] v);
        if (v > ONE_LVL - 1) v = ONE_LVL - 1;
        return (v == 0) ? 64'd1 : v;
    endfunction

    function automatic bit [63:0] step_clamp(bit [63:0] v);
        return (v > ONE_LVL) ? ONE_LVL : v;
    endfunction

    function automatic void model_reset();
        r_step_start = ONE_LVL;
        r_step_ramp = 64'(RAMP_ONE);
        r_scale_start = 64'(SCALE_RESET);
        r_scale_ramp = 64'(RAMP_ONE);
        r_fold_start = 64'(FOLD_RESET);
        r_fold_ramp = 64'(RAMP_ONE);
        last_in = 0;
        held_out = 0;
        phase = 0;
        cur_step = ONE_LVL;
        cur_scale = 64'(SCALE_RESET);
        cur_fold = 64'(FOLD_RESET);
    endfunction

    function automatic void model_write(logic [CFG_IDX_BITS-1:0] idx, logic [32:0] d);
        case (idx)
            CFG_STEP_START:  r_step_start = 64'(d);
            CFG_STEP_RAMP:   r_step_ramp = 64'(d[31:0]);
            CFG_SCALE_START: r_scale_start = 64'(d[31:0]);
            CFG_SCALE_RAMP:  r_scale_ramp = 64'(d[31:0]);
            CFG_FOLD_START:  r_fold_start = 64'(d[31:0]);
            CFG_FOLD_RAMP:   r_fold_ramp = 64'(d[31:0]);
            default: ;
        endcase
    endfunction

    // one sample through the crusher model; updates model state
    function automatic logic signed [SB-1:0] crush(logic signed [SB-1:0] smp, logic tick);
        longint x, res, xw, pw, lerped, fold, wrap, t, folded, scl, n, new_s;
        bit [63:0] sum, ph, rem, ratio;
        x = longint'(smp);
        if (tick) begin
            cur_step = step_clamp(r_step_start);
            cur_scale = level_clamp(r_scale_start);
            cur_fold = level_clamp(r_fold_start);
        end
        if (x == 0) return '0;
        sum = phase + cur_step;
        if (sum < ONE_LVL || cur_step == 0) begin
            phase = sum & (ONE_LVL - 1);
            last_in = x;
            res = held_out;
        end else begin
            ph = sum - ONE_LVL;
            phase = ph & (ONE_LVL - 1);
            rem = ph;
            ratio = 0;
            // restoring division: ratio = floor(ph * 2^FB / step)
            for (int i = 0; i < FB; i++) begin
                rem = rem << 1;
                ratio = ratio << 1;
                if (rem >= cur_step) begin
                    rem = rem - cur_step;
                    ratio[0] = 1'b1;
                end
            end
            xw = x <<< (FB - SB + 1);
            pw = last_in <<< (FB - SB + 1);
            lerped = xw + frac_mul(pw - xw, ratio);
            last_in = x;
            // triangle fold into [-fold, +fold]
            fold = longint'(cur_fold);
            wrap = fold * 4;
            t = (lerped + fold) % wrap;
            if (t < 0) t += wrap;
            t = fold * 2 - t;
            if (t < 0) t = -t;
            folded = fold - t;
            // quantize to step midpoints
            scl = longint'(cur_scale);
            n = folded / scl + ((folded > 0) ? 1 : 0);
            new_s = (((2 * n - 1) * scl) >>> 1) >>> (FB - SB + 1);
            if (new_s > SMAX) new_s = SMAX;
            if (new_s < SMIN) new_s = SMIN;
            res = held_out + frac_mul(new_s - held_out, ratio);
            if (res > SMAX) res = SMAX;
            if (res < SMIN) res = SMIN;
            held_out = new_s;
        end
        cur_step = step_clamp(ramp_mul(cur_step, r_step_ramp, RAMP_FRAC));
        cur_scale = level_clamp(ramp_mul(cur_scale, r_scale_ramp, RAMP_FRAC));
        cur_fold = level_clamp(ramp_mul(cur_fold, r_fold_ramp, RAMP_FRAC));
        return res[SB-1:0];
    endfunction

    // input driver: payload changes on the falling edge only
    always @(negedge clk) begin
        sample_item_t it;
        if (rst_n && !(in_valid && sent_cnt != taken_cnt)) begin
            if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                it = pending_q.pop_front();
                sample_in <= it.smp;
                start_tick <= it.tick;
                in_valid <= 1'b1;
                sent_cnt <= sent_cnt + 1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_ready <= rst_n && ($urandom_range(0, 99) >= stall_pct);
    end

    // monitor: predict on input transfer, check on output transfer
    always @(posedge clk) begin
        logic signed [SB-1:0] want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) model_write(cfg_index, cfg_data);
            if (in_valid && in_ready) begin
                crushed_q.push_back(crush(sample_in, start_tick));
                taken_cnt <= taken_cnt + 1;
            end
            if (out_valid && out_ready) begin
                if (crushed_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected output transfer: sample_out=%0d", sample_out);
                end else begin
                    want = crushed_q.pop_front();
                    if (sample_out !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("sample_out mismatch: expected %0d got %0d",
                                     want, sample_out);
                    end
                end
            end
            // watchdog only runs while work is outstanding
            if ((in_valid && in_ready) || (out_valid && out_ready)
                || (pending_q.size() == 0 && crushed_q.size() == 0 && !in_valid))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= WD_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic cfg_write(cfg_idx_t idx, logic [32:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic drain();
        wait (pending_q.size() == 0 && sent_cnt == taken_cnt && crushed_q.size() == 0);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic signed [SB-1:0] rand_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 11) return SMAX[SB-1:0];
        if (r < 14) return SMIN[SB-1:0];
        if (r < 17) return ($urandom_range(0, 1) != 0) ? 24'sd1 : -24'sd1;
        return SB'($urandom());
    endfunction

    function automatic logic [31:0] near_one();
        return RAMP_ONE + $urandom_range(0, 4000000) - 2000000;
    endfunction

    task automatic push(logic signed [SB-1:0] s, logic tk);
        sample_item_t it;
        it.smp = s;
        it.tick = tk;
        pending_q.push_back(it);
    endtask

    task automatic push_random(int cnt);
        repeat (cnt) push(rand_sample(), $urandom_range(0, 19) == 0);
    endtask

    // random mid-range setting with ramps close to unity
    task automatic cfg_random();
        cfg_write(CFG_STEP_START, 33'($urandom_range(1, 32'hFFFF_FFFF)));
        cfg_write(CFG_STEP_RAMP, 33'(near_one()));
        cfg_write(CFG_SCALE_START, 33'($urandom_range(1, 32'h0100_0000)));
        cfg_write(CFG_SCALE_RAMP, 33'(near_one()));
        cfg_write(CFG_FOLD_START, 33'($urandom_range(32'h0100_0000, 32'hFFFF_FFFF)));
        cfg_write(CFG_FOLD_RAMP, 33'(near_one()));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        model_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, extremes, zero samples, reloads
        push(24'sd0, 1'b0);
        push(SMAX[SB-1:0], 1'b0);
        push(SMIN[SB-1:0], 1'b0);
        push(24'sd1, 1'b1);
        push(-24'sd1, 1'b0);
        push(24'sd0, 1'b1);
        push(24'sh555555, 1'b0);
        push(-24'sh2AAAAB, 1'b0);
        drain();

        // step above one, zero scale and fold, ramps at both ends
        cfg_write(CFG_STEP_START, 33'h1_FFFF_FFFF);
        cfg_write(CFG_STEP_RAMP, 33'd0);
        cfg_write(CFG_SCALE_START, 33'd0);
        cfg_write(CFG_SCALE_RAMP, 33'h0_FFFF_FFFF);
        cfg_write(CFG_FOLD_START, 33'd0);
        cfg_write(CFG_FOLD_RAMP, 33'h0_FFFF_FFFF);
        cfg_write(cfg_idx_t'(3'd6), 33'h0_1234_5678);
        cfg_write(cfg_idx_t'(3'd7), 33'h1_0000_0000);
        @(negedge clk);
        cfg_valid <= 1'b0;
        push(SMAX[SB-1:0], 1'b1);
        push(SMIN[SB-1:0], 1'b0);
        push(24'sd12345, 1'b0);
        push(-24'sd777, 1'b0);
        push(24'sd0, 1'b0);
        drain();

        // zero step: phase stalls, held output repeats
        cfg_write(CFG_STEP_START, 33'd0);
        cfg_write(CFG_FOLD_START, 33'h0_FFFF_FFFF);
        cfg_write(CFG_SCALE_START, 33'h0_FFFF_FFFF);
        cfg_write(CFG_STEP_RAMP, 33'(RAMP_ONE));
        @(negedge clk);
        cfg_valid <= 1'b0;
        push(SMAX[SB-1:0], 1'b1);
        push(-24'sd9, 1'b0);
        push(24'sd3, 1'b0);
        push(24'sd1000000, 1'b0);
        drain();

        // random phases over the idling modes
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 69; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 69; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            cfg_random();
            push_random(80);
            // sender holds off until the crusher has fully drained
            drain();
            push_random(80);
            drain();
        end

        // stretch without idling
        send_idle_pct = 0;
        stall_pct = 0;
        drain();
        repeat (400) @(posedge clk);
        if (mismatch_cnt == 0 && crushed_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
